@@ src/bpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfa_pkg
// shared types, codes and defaults of the bitmap page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

    // default geometry
    localparam int DEF_BITMAP_BYTES = 512;
    localparam int DEF_PAGE_BYTES   = 4096;

    // width of the page counters
    localparam int CW = 13;

    typedef enum logic [1:0] {
        FN_ADD     = 2'd0,
        FN_ALLOC   = 2'd1,
        FN_RELEASE = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOPAGE  = 2'd1,
        ST_BADREL  = 2'd2,
        ST_CLIPPED = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [31:0] address;
        logic [31:0] length;
    } t_req;

    typedef struct packed {
        logic [31:0]   page_address;
        t_status       status;
        logic [CW-1:0] free_count;
        logic [CW-1:0] total_pages;
        logic [CW-1:0] upper_page;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted request
        logic setup;     // align range base and length
        logic clip;      // clip range to bitmap, update add counters
        logic rd;        // read bitmap byte at the byte pointer
        logic init_wr;   // write all ones, advance pointer
        logic add_wr;    // clear range bits in the byte just read
        logic scan_chk;  // test byte just read for a free page
        logic rel_wr;    // release the page bit in the byte just read
        logic publish;   // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic clip_empty;
        logic add_last;
        logic scan_found;
        logic scan_last;
        logic rel_bad;
        logic out_busy;
    } t_sts;

endpackage

@@ src/bpfa_dp.sv @@
// ----------------------------------------------------------------------------
// bpfa_dp
// bitmap memory, byte pointer, range arithmetic, counters and result register
// ----------------------------------------------------------------------------
module bpfa_dp
    import bpfa_pkg::*;
#(
    parameter int BITMAP_BYTES = DEF_BITMAP_BYTES,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    input  logic i_out_ready,
    output t_sts o_sts,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int NUM_PAGES = BITMAP_BYTES * 8;
    localparam int PB_BITS   = $clog2(PAGE_BYTES);
    localparam int BYTE_AW   = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int PG_W      = $clog2(NUM_PAGES + 1);
    localparam int SW_W      = 33 - PB_BITS;
    localparam int XW        = ((SW_W > PG_W) ? SW_W : PG_W) + 1;
    localparam int CAP_I     = (NUM_PAGES < 8191) ? NUM_PAGES : 8191;

    localparam logic [XW-1:0]      NUM_X     = XW'(NUM_PAGES);
    localparam logic [XW-1:0]      CAP_X     = XW'(CAP_I);
    localparam logic [BYTE_AW-1:0] LAST_BYTE = BYTE_AW'(BITMAP_BYTES - 1);
    localparam logic [31:0]        PB_MASK   = 32'(PAGE_BYTES - 1);
    localparam logic [31:0]        PB_SIZE   = 32'(PAGE_BYTES);

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [XW-1:0] b);
        logic [XW-1:0] s;
        s = XW'(a) + b;
        return (s > CAP_X) ? CW'(CAP_X) : CW'(s);
    endfunction

    logic [7:0] mem [BITMAP_BYTES];

    logic [31:0]        r_address;
    logic [31:0]        r_length;
    logic [BYTE_AW-1:0] r_addr;
    logic [7:0]         r_rdata;
    logic [SW_W-1:0]    r_start;
    logic [SW_W-1:0]    r_count;
    logic [2:0]         r_start_lo;
    logic [2:0]         r_end_lo;
    logic [BYTE_AW-1:0] r_first;
    logic [BYTE_AW-1:0] r_last;
    logic [2:0]         r_bit;
    logic               r_rel_bad;
    t_status            r_status;
    logic [31:0]        r_page_addr;
    logic [CW-1:0]      r_free;
    logic [CW-1:0]      r_added;
    logic [CW-1:0]      r_high;
    logic               r_out_valid;
    t_rsp               r_out;

    // release decode of the incoming request
    logic [XW-1:0] rel_page;

    // range alignment
    logic            low_nz;
    logic [31:0]     skip;
    logic [SW_W-1:0] setup_start;
    logic [SW_W-1:0] setup_count;

    // clipping
    logic [XW-1:0] start_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] rem_x;
    logic [XW-1:0] count_c;
    logic [XW-1:0] end_x;
    logic [XW-1:0] end_m1;
    logic          start_ge;
    logic          clipped;
    logic          empty;

    // per-byte work
    logic [2:0]  lo_bit;
    logic [2:0]  hi_bit;
    logic [7:0]  add_mask;
    logic [7:0]  hit;
    logic [3:0]  hit_cnt;
    logic [2:0]  alloc_bit;
    logic [63:0] alloc_wide;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    assign rel_page = XW'(i_req.address >> PB_BITS);

    assign low_nz      = |(r_address & PB_MASK);
    assign skip        = low_nz ? (PB_SIZE - (r_address & PB_MASK)) : 32'd0;
    assign setup_start = SW_W'(r_address >> PB_BITS) + SW_W'(low_nz);
    assign setup_count = (r_length > skip) ? SW_W'((r_length - skip) >> PB_BITS)
                                           : '0;

    assign start_x  = XW'(r_start);
    assign count_x  = XW'(r_count);
    assign start_ge = (start_x >= NUM_X);
    assign rem_x    = NUM_X - start_x;
    assign clipped  = !start_ge && (count_x > rem_x);
    assign count_c  = start_ge ? '0 : (clipped ? rem_x : count_x);
    assign empty    = (count_c == '0);
    assign end_x    = start_x + count_c;
    assign end_m1   = end_x - XW'(1);

    assign lo_bit   = (r_addr == r_first) ? r_start_lo : 3'd0;
    assign hi_bit   = (r_addr == r_last) ? r_end_lo : 3'd7;
    assign add_mask = (8'hff << lo_bit) & (8'hff >> (3'd7 - hi_bit));
    assign hit      = r_rdata & add_mask;

    always_comb begin
        hit_cnt = '0;
        for (int i = 0; i < 8; i++) begin
            hit_cnt = hit_cnt + 4'(hit[i]);
        end
    end

    // lowest clear bit of the byte just read
    always_comb begin
        alloc_bit = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (!r_rdata[i]) begin
                alloc_bit = 3'(i);
            end
        end
    end

    assign alloc_wide = 64'({r_addr, alloc_bit}) << PB_BITS;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        if (i_cmd.init_wr) begin
            mem_we    = 1'b1;
            mem_wdata = 8'hff;
        end else if (i_cmd.add_wr) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata & ~add_mask;
        end else if (i_cmd.scan_chk && (r_rdata != 8'hff)) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata | (8'h01 << alloc_bit);
        end else if (i_cmd.rel_wr && r_rdata[r_bit]) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata & ~(8'h01 << r_bit);
        end
    end

    // bitmap storage
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_addr];
        end
    end

    // request, range and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_address   <= i_req.address;
            r_length    <= i_req.length;
            r_bit       <= rel_page[2:0];
            r_rel_bad   <= (rel_page >= NUM_X);
            r_page_addr <= '0;
            r_status    <= ((i_req.func == FN_RELEASE) && (rel_page >= NUM_X)) ?
                           ST_BADREL : ST_OK;
        end
        if (i_cmd.setup) begin
            r_start <= setup_start;
            r_count <= setup_count;
        end
        if (i_cmd.clip) begin
            r_status   <= (empty || clipped) ? ST_CLIPPED : ST_OK;
            r_first    <= start_x[BYTE_AW+2:3];
            r_last     <= end_m1[BYTE_AW+2:3];
            r_start_lo <= start_x[2:0];
            r_end_lo   <= end_m1[2:0];
        end
        if (i_cmd.scan_chk) begin
            if (r_rdata != 8'hff) begin
                r_page_addr <= alloc_wide[31:0];
            end else if (r_addr == LAST_BYTE) begin
                r_status <= ST_NOPAGE;
            end
        end
        if (i_cmd.rel_wr && !r_rdata[r_bit]) begin
            r_status <= ST_BADREL;
        end
        if (i_cmd.publish) begin
            r_out.page_address <= r_page_addr;
            r_out.status       <= r_status;
            r_out.free_count   <= r_free;
            r_out.total_pages  <= r_added;
            r_out.upper_page   <= r_high;
        end
    end

    // byte pointer, counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_free      <= '0;
            r_added     <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_addr <= (i_req.func == FN_RELEASE) ? rel_page[BYTE_AW+2:3] : '0;
            end
            if (i_cmd.init_wr) begin
                r_addr <= r_addr + BYTE_AW'(1);
            end
            if (i_cmd.clip && !empty) begin
                r_addr  <= start_x[BYTE_AW+2:3];
                r_added <= sat_add(r_added, count_c);
                if (end_x > XW'(r_high)) begin
                    r_high <= (end_x > CAP_X) ? CW'(CAP_X) : CW'(end_x);
                end
            end
            if (i_cmd.add_wr) begin
                r_free <= sat_add(r_free, XW'(hit_cnt));
                r_addr <= r_addr + BYTE_AW'(1);
            end
            if (i_cmd.scan_chk) begin
                if (r_rdata != 8'hff) begin
                    if (r_free != '0) begin
                        r_free <= r_free - CW'(1);
                    end
                end else if (r_addr != LAST_BYTE) begin
                    r_addr <= r_addr + BYTE_AW'(1);
                end
            end
            if (i_cmd.rel_wr && r_rdata[r_bit]) begin
                r_free <= sat_add(r_free, XW'(1));
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.init_last  = (r_addr == LAST_BYTE);
    assign o_sts.clip_empty = empty;
    assign o_sts.add_last   = (r_addr == r_last);
    assign o_sts.scan_found = (r_rdata != 8'hff);
    assign o_sts.scan_last  = (r_addr == LAST_BYTE);
    assign o_sts.rel_bad    = r_rel_bad;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

@@ src/bpfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// bpfa_ctrl
// sequencer: bitmap fill after reset, then one request at a time
// ----------------------------------------------------------------------------
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_func i_func,
    input  t_sts  i_sts,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_CLIP,
        S_ADD_RD,
        S_ADD_WR,
        S_ALC_RD,
        S_ALC_CHK,
        S_REL_RD,
        S_REL_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_func)
                        FN_ADD:     n_state = S_SETUP;
                        FN_ALLOC:   n_state = S_ALC_RD;
                        FN_RELEASE: n_state = S_REL_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_CLIP;
            end
            S_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = i_sts.clip_empty ? S_DONE : S_ADD_RD;
            end
            S_ADD_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state      = i_sts.add_last ? S_DONE : S_ADD_RD;
            end
            S_ALC_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ALC_CHK;
            end
            S_ALC_CHK: begin
                o_cmd.scan_chk = 1'b1;
                n_state = (i_sts.scan_found || i_sts.scan_last) ? S_DONE : S_ALC_RD;
            end
            S_REL_RD: begin
                if (i_sts.rel_bad) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_REL_WR;
                end
            end
            S_REL_WR: begin
                o_cmd.rel_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ src/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// physical page allocator over a one-bit-per-page usage bitmap
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. A set bitmap bit marks a page in
// use. func add frees every whole page of a byte range (base rounded up to a
// page, length trimmed down, range cut at the end of the bitmap with status
// clipped), allocate claims the lowest free page, release frees one used page.
// Timing: after reset the block sweeps the bitmap memory writing all ones, one
// byte per cycle, so o_ready first rises once the last byte has been written.
// Requests are then taken one at a time; the bitmap is a single-port memory
// with a registered read, and each byte visited is first read and then
// modified. Add runs a setup step and a clip step and then visits each bitmap
// byte spanned (none when the range is empty); allocate visits bytes from the
// first until one holds a free page or the last byte is checked; release
// visits the page's byte (none when the page lies past the bitmap); func 3
// goes straight to the result. The result register is then loaded, and
// o_ready comes back the cycle after that load. The result beat sits in an
// output register; a new request is taken while the previous result still
// waits there, and the load of the next result waits for as long as the old
// beat has not been taken.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
#(
    parameter int BITMAP_BYTES = DEF_BITMAP_BYTES,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    // result channel
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    // counter ceiling, for checking only
    localparam int CAP_I = (BITMAP_BYTES * 8 < 8191) ? BITMAP_BYTES * 8 : 8191;

    t_cmd cmd;
    t_sts sts;

    // sequencer: decides which datapath step runs each cycle
    bpfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_req.func),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    // bitmap memory, range math, counters and result register
    bpfa_dp #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_out_ready (i_ready),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    // a taken request keeps the sequencer busy for at least the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("request taken while previous one still in flight");

    // the result register is only loaded when its old beat is gone
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> !(o_valid && !i_ready)
    ) else $error("result beat overwritten before it was taken");

    // only a successful allocate returns a nonzero page address
    a_addr_on_fail: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != ST_OK)) |-> (o_rsp.page_address == 32'd0)
    ) else $error("page address on a failed request");

    // counters never pass the ceiling
    a_count_cap: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_rsp.free_count <= CW'(CAP_I)) &&
                     (o_rsp.total_pages <= CW'(CAP_I)) &&
                     (o_rsp.upper_page <= CW'(CAP_I)))
    ) else $error("page counter above ceiling");

endmodule
